// File: src/process_id_table_assert.svh
// Assertion macros for the process id table.
// Depends on a clk and an active-low arst_n being visible where a macro is used.
`ifndef PROCESS_ID_TABLE_ASSERT_SVH
`define PROCESS_ID_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pit_pkg.sv
// Package for the process id table: field widths, operation and status codes,
// controller state type. No dependencies.
`default_nettype none

package pit_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int ID_WIDTH_DEF = 16;

	localparam int OP_W        = 2;
	localparam int PID_W       = 16;
	localparam int HANDLE_W    = 16;
	localparam int STAT_W      = 2;
	localparam int POS_W       = 6;
	localparam int CNT_W       = 7;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

// File: src/process_id_table.sv
// Process id table: an ordered, compacting table of {id, handle} entries kept
// in one simple dual-port RAM (one write, one registered read per cycle).
// One beat in on s_axis gives one beat out on m_axis. Insert appends a new id
// (duplicate reported with the existing entry, full table refused), lookup
// returns the first matching position, remove deletes the match and moves
// every later entry down one place. Each result carries the entry count after
// the operation and an empty flag. Items are handled one at a time; the cost
// is set by the linear scan, one RAM read per cycle with the compare in the
// cycle after each read, and remove adds the compacting copy, again one RAM
// read and one write per cycle. The next beat can be accepted in the cycle
// after the result is loaded. The finished result sits in an output register,
// so a new beat is accepted while it waits to be taken.
// Unused operation code 3 reports not found without touching the table.
// Only the low ID_WIDTH bits of process_id take part in matching. Entries are
// read only below the fill count, so the RAM needs no clearing after reset.
// Depends on pit_pkg and process_id_table_assert.svh.
`default_nettype none

`include "process_id_table_assert.svh"

module process_id_table #(
	parameter int CAPACITY = pit_pkg::CAPACITY_DEF,
	parameter int ID_WIDTH = pit_pkg::ID_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// slave side
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [15:0] process_id, [31:16] entry_handle
	input  wire logic [pit_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [1:0] operation
	input  wire logic [pit_pkg::OP_W-1:0]            s_axis_tuser,
	// master side
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [5:0] position, [21:6] found_handle, [28:22] entry_count, [29] is_empty,
	// [31:30] zero
	output logic [pit_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	// [1:0] status
	output logic [pit_pkg::STAT_W-1:0]               m_axis_tuser
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int HW = pit_pkg::HANDLE_W;
	localparam int MW = ID_WIDTH + HW;

	// RAM: id in the low bits, handle above it
	logic [MW-1:0] mem [CAPACITY];

	pit_pkg::state_t state_q, state_next;

	logic [pit_pkg::OP_W-1:0]   op_q;
	logic [ID_WIDTH-1:0]        id_q;
	logic [HW-1:0]              hnd_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              rd_ptr_q;
	logic                       vld_s1;
	logic [AW-1:0]              addr_s1;
	logic [MW-1:0]              rd_data_s1;

	logic [pit_pkg::STAT_W-1:0] res_status_q;
	logic [AW-1:0]              res_pos_q;
	logic [HW-1:0]              res_hnd_q;

	logic                       m_tvalid_q;
	logic [pit_pkg::OUT_TDATA_W-1:0] out_tdata_q;
	logic [pit_pkg::STAT_W-1:0] out_tuser_q;

	// control decoded from the state
	logic          accept;
	logic          rd_en;
	logic          hit;
	logic          miss;
	logic          ins_wr;
	logic          sh_wr;
	logic          shift_end;
	logic          out_load;
	logic          full;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	logic [31:0]         pid_wide;
	logic [ID_WIDTH-1:0] id_in;
	logic [31:0]         pos_wide;
	logic [31:0]         cnt_wide;

	// Keep the low ID_WIDTH bits of the id, zero-extended for wide ids.
	assign pid_wide = 32'(s_axis_tdata[pit_pkg::PID_W-1:0]);
	assign id_in    = pid_wide[ID_WIDTH-1:0];
	assign full     = (count_q >= CW'(CAPACITY));

	// Outputs of the controller.
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		hit           = 1'b0;
		miss          = 1'b0;
		ins_wr        = 1'b0;
		sh_wr         = 1'b0;
		shift_end     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			pit_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			pit_pkg::S_SCAN: begin
				// Issue one read a cycle, compare the previous one.
				rd_en  = (rd_ptr_q < count_q);
				hit    = vld_s1 && (rd_data_s1[ID_WIDTH-1:0] == id_q);
				miss   = !vld_s1 && (rd_ptr_q == count_q);
				ins_wr = miss && (op_q == pit_pkg::OP_INSERT) && !full;
			end
			pit_pkg::S_SHIFT: begin
				// Read entry k+1, write it into k in the next cycle.
				rd_en     = (rd_ptr_q < count_q);
				sh_wr     = vld_s1;
				shift_end = !vld_s1 && (rd_ptr_q == count_q);
			end
			pit_pkg::S_RESULT: begin
				out_load = !m_tvalid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			pit_pkg::S_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == pit_pkg::OP_NONE)
						state_next = pit_pkg::S_RESULT;
					else
						state_next = pit_pkg::S_SCAN;
				end
			end
			pit_pkg::S_SCAN: begin
				if (hit) begin
					if (op_q == pit_pkg::OP_REMOVE)
						state_next = pit_pkg::S_SHIFT;
					else
						state_next = pit_pkg::S_RESULT;
				end else if (miss) begin
					state_next = pit_pkg::S_RESULT;
				end
			end
			pit_pkg::S_SHIFT: begin
				if (shift_end)
					state_next = pit_pkg::S_RESULT;
			end
			pit_pkg::S_RESULT: begin
				if (out_load)
					state_next = pit_pkg::S_IDLE;
			end
			default: begin
				state_next = pit_pkg::S_IDLE;
			end
		endcase
	end

	// Write port: append on insert, move down during compaction.
	assign wr_en   = ins_wr || sh_wr;
	assign wr_addr = ins_wr ? count_q[AW-1:0] : (addr_s1 - AW'(1));
	assign wr_data = ins_wr ? {hnd_q, id_q} : rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pit_pkg::S_IDLE;
			count_q    <= '0;
			rd_ptr_q   <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;

			if (ins_wr)
				count_q <= count_q + CW'(1);
			else if (shift_end)
				count_q <= count_q - CW'(1);

			if (accept) begin
				rd_ptr_q <= '0;
				vld_s1   <= 1'b0;
			end else if (hit && (op_q == pit_pkg::OP_REMOVE)) begin
				// restart the read pointer just past the removed entry
				rd_ptr_q <= CW'(addr_s1) + CW'(1);
				vld_s1   <= 1'b0;
			end else if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
				vld_s1   <= 1'b1;
			end else begin
				vld_s1   <= 1'b0;
			end

			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_axis_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign pos_wide = 32'(res_pos_q);
	assign cnt_wide = 32'(count_q);

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rd_en)
			addr_s1 <= rd_ptr_q[AW-1:0];

		if (accept) begin
			op_q         <= s_axis_tuser;
			id_q         <= id_in;
			hnd_q        <= s_axis_tdata[pit_pkg::PID_W +: HW];
			res_status_q <= pit_pkg::STAT_NOTFOUND;
			res_pos_q    <= '0;
			res_hnd_q    <= '0;
		end else if (hit) begin
			res_pos_q <= addr_s1;
			res_hnd_q <= rd_data_s1[ID_WIDTH +: HW];
			if (op_q == pit_pkg::OP_INSERT)
				res_status_q <= pit_pkg::STAT_DUP;
			else
				res_status_q <= pit_pkg::STAT_DONE;
		end else if (miss && (op_q == pit_pkg::OP_INSERT)) begin
			if (full) begin
				res_status_q <= pit_pkg::STAT_FULL;
			end else begin
				res_status_q <= pit_pkg::STAT_DONE;
				res_pos_q    <= count_q[AW-1:0];
			end
		end

		// count_q already holds the count after the operation here
		if (out_load) begin
			out_tuser_q <= res_status_q;
			out_tdata_q <= {2'b00,
				(count_q == '0),
				cnt_wide[pit_pkg::CNT_W-1:0],
				res_hnd_q,
				pos_wide[pit_pkg::POS_W-1:0]};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;

	`PIT_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "entry count beyond capacity")
	`PIT_ASSERT_NOW(a_wr_state, wr_en, state_q == pit_pkg::S_SCAN || state_q == pit_pkg::S_SHIFT, "RAM write outside scan or shift")
	`PIT_ASSERT_NEXT(a_accept_busy, accept, state_q != pit_pkg::S_IDLE, "accepted beat did not start work")
	`PIT_ASSERT_NEXT(a_remove_dec, shift_end, count_q == CW'($past(count_q) - CW'(1)), "remove did not drop the count by one")

endmodule

`default_nettype wire
